>>> design/grpm_pkg.sv
// Package for the gapped row position mapper: command codes, widths, sizes.
// No dependencies.
`default_nettype none
package grpm_pkg;
  localparam int MaxColumns = 4096;
  localparam int MaxRuns    = 2048;
  localparam int RunAw      = 12;                 // address bits for MaxRuns+1 entries
  localparam int RunDepth   = MaxRuns + 1;
  localparam int PosW       = 12;
  localparam int CntW       = 13;
  localparam logic [7:0] GapChar = 8'd45;

  localparam logic [2:0] CmdClear   = 3'd0;
  localparam logic [2:0] CmdAppend  = 3'd1;
  localparam logic [2:0] CmdExact   = 3'd2;
  localparam logic [2:0] CmdLeft    = 3'd3;
  localparam logic [2:0] CmdRight   = 3'd4;
  localparam logic [2:0] CmdNearest = 3'd5;
  localparam logic [2:0] CmdIndex   = 3'd6;
  localparam logic [2:0] CmdNone    = 3'd7;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [7:0]      column_char;
    logic [PosW-1:0] position;
  } req_t;

  typedef struct packed {
    logic [PosW-1:0] mapped_position;
    logic            found;
    logic            out_of_range;
    logic [CntW-1:0] row_columns;
    logic [CntW-1:0] sequence_letters;
  } rsp_t;
endpackage
`default_nettype wire

>>> design/grpm_if.sv
// Valid/ready channel interfaces for request and response.
// Depends on grpm_pkg.
`default_nettype none
interface grpm_req_if;
  logic              valid;
  logic              ready;
  grpm_pkg::req_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface grpm_rsp_if;
  logic              valid;
  logic              ready;
  grpm_pkg::rsp_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> design/grpm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module grpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> design/grpm_front.sv
// Front end: accepts requests, drops unused commands, queues two entries deep.
// Depends on grpm_pkg.
`default_nettype none
module grpm_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire grpm_pkg::req_t in_req_i,
  output      logic           q_valid_o,
  input  wire logic           q_pop_i,
  output      grpm_pkg::req_t q_req_o
);
  import grpm_pkg::*;
  req_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o && (in_req_i.cmd != CmdNone);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule
`default_nettype wire

>>> design/grpm_back.sv
// Back end: run table, appends and binary-search queries, one request at a time.
// Depends on grpm_pkg and grpm_ram.
`default_nettype none
module grpm_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  output      logic           q_pop_o,
  input  wire grpm_pkg::req_t q_req_i,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output      grpm_pkg::rsp_t out_rsp_o
);
  import grpm_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StProbe = 3'd1;
  localparam logic [2:0] StWait = 3'd2;
  localparam logic [2:0] StNext = 3'd3;
  localparam logic [2:0] StNextW = 3'd4;
  localparam logic [2:0] StFin = 3'd5;
  localparam logic [2:0] StOut = 3'd6;

  logic [2:0]       st_q;
  req_t             req_q;
  logic [RunAw-1:0] run_cnt_q;
  logic [CntW-1:0]  col_tot_q, let_tot_q;
  logic             prev_gap_q;
  logic [RunAw:0]   first_q, count_q;
  logic [RunAw-1:0] probe_q;
  logic [CntW-1:0]  sc_q, fi_q;
  rsp_t             rsp_q;

  logic             we;
  logic [RunAw-1:0] addr;
  logic [CntW-1:0]  sc_rd, fi_rd;
  logic             is_letter, opens;
  logic [RunAw:0]   half;
  logic [CntW-1:0]  key, pos_x;
  logic             go_right, has_next;
  logic [CntW-1:0]  next_first, glen, col_off, left_d, right_d, res;
  logic             fnd, idxq;

  grpm_ram #(.Width(CntW), .Depth(RunDepth)) u_sc (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(col_tot_q), .rdata_o(sc_rd));
  grpm_ram #(.Width(CntW), .Depth(RunDepth)) u_fi (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(let_tot_q), .rdata_o(fi_rd));

  assign is_letter = (q_req_i.column_char != GapChar);
  assign opens = is_letter && prev_gap_q;
  assign idxq = (req_q.cmd == CmdIndex);
  assign pos_x = {1'b0, req_q.position};
  assign half = count_q >> 1;
  assign key = idxq ? fi_rd : sc_rd;
  assign go_right = !(pos_x < key);
  assign has_next = (first_q < {1'b0, run_cnt_q});

  always_comb begin
    we = 1'b0;
    addr = probe_q;
    if (st_q == StIdle && q_valid_i && q_req_i.cmd == CmdAppend &&
        col_tot_q < CntW'(MaxColumns) && opens && run_cnt_q < RunAw'(MaxRuns)) begin
      we = 1'b1;
      addr = run_cnt_q;
    end
  end

  // Final mapping from the run at first-1 (fi_q/sc_q) and its successor, whose
  // entry sits on the RAM read port during the final state.
  always_comb begin
    next_first = has_next ? fi_rd : let_tot_q;
    glen = next_first - fi_q;
    col_off = pos_x - sc_q;
    left_d = col_off - glen + 1'b1;
    right_d = sc_rd - pos_x;
    fnd = 1'b0;
    res = '0;
    if (idxq) begin
      fnd = (first_q != '0);
      res = sc_q + (pos_x - fi_q);
    end else if (first_q == '0) begin
      fnd = !(req_q.cmd == CmdExact || req_q.cmd == CmdLeft || run_cnt_q == '0);
    end else if (col_off < glen) begin
      fnd = 1'b1;
      res = fi_q + col_off;
    end else if (req_q.cmd == CmdExact) begin
      fnd = 1'b0;
    end else if (req_q.cmd == CmdLeft) begin
      fnd = 1'b1;
      res = next_first - 1'b1;
    end else if (!has_next) begin
      fnd = !(req_q.cmd == CmdRight || let_tot_q == '0);
      res = let_tot_q - 1'b1;
    end else if (req_q.cmd == CmdRight) begin
      fnd = 1'b1;
      res = next_first;
    end else begin
      fnd = 1'b1;
      res = (left_d <= right_d) ? next_first - 1'b1 : next_first;
    end
  end

  assign q_pop_o = (st_q == StIdle) && q_valid_i;
  assign out_valid_o = (st_q == StOut);
  assign out_rsp_o = rsp_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) req_q <= q_req_i;
    if (st_q == StNext && !(count_q != '0)) begin
      sc_q <= sc_rd;
      fi_q <= fi_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      run_cnt_q <= '0;
      col_tot_q <= '0;
      let_tot_q <= '0;
      prev_gap_q <= 1'b1;
      first_q <= '0;
      count_q <= '0;
      probe_q <= '0;
      rsp_q <= '0;
    end else begin
      case (st_q)
        StIdle: if (q_valid_i) begin
          rsp_q.mapped_position <= '0;
          rsp_q.found <= 1'b0;
          rsp_q.out_of_range <= 1'b0;
          st_q <= StOut;
          case (q_req_i.cmd)
            CmdClear: begin
              run_cnt_q <= '0;
              col_tot_q <= '0;
              let_tot_q <= '0;
              prev_gap_q <= 1'b1;
              rsp_q.row_columns <= '0;
              rsp_q.sequence_letters <= '0;
            end
            CmdAppend: begin
              rsp_q.row_columns <= col_tot_q;
              rsp_q.sequence_letters <= let_tot_q;
              if (col_tot_q >= CntW'(MaxColumns) ||
                  (opens && run_cnt_q >= RunAw'(MaxRuns))) begin
                rsp_q.out_of_range <= 1'b1;
              end else begin
                if (opens) run_cnt_q <= run_cnt_q + 1'b1;
                if (is_letter) let_tot_q <= let_tot_q + 1'b1;
                col_tot_q <= col_tot_q + 1'b1;
                prev_gap_q <= !is_letter;
                rsp_q.row_columns <= col_tot_q + 1'b1;
                rsp_q.sequence_letters <= let_tot_q + CntW'(is_letter);
              end
            end
            default: begin
              rsp_q.row_columns <= col_tot_q;
              rsp_q.sequence_letters <= let_tot_q;
              if ({1'b0, q_req_i.position} >=
                  ((q_req_i.cmd == CmdIndex) ? let_tot_q : col_tot_q)) begin
                rsp_q.out_of_range <= 1'b1;
              end else begin
                first_q <= '0;
                count_q <= {1'b0, run_cnt_q};
                st_q <= StProbe;
              end
            end
          endcase
        end
        StProbe: begin
          if (count_q == '0) begin
            probe_q <= RunAw'(first_q - 1'b1);
            st_q <= StWait;
          end else begin
            probe_q <= RunAw'(first_q + half);
            st_q <= StWait;
          end
        end
        StWait: st_q <= StNext;
        StNext: begin
          if (count_q == '0) begin
            probe_q <= RunAw'(first_q);
            st_q <= StNextW;
          end else begin
            if (go_right) begin
              first_q <= first_q + half + 1'b1;
              count_q <= count_q - half - 1'b1;
            end else begin
              count_q <= half;
            end
            st_q <= StProbe;
          end
        end
        StNextW: st_q <= StFin;
        StFin: begin
          rsp_q.found <= fnd;
          rsp_q.mapped_position <= fnd ? res[PosW-1:0] : '0;
          st_q <= StOut;
        end
        StOut: if (out_ready_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/gapped_row_position_mapper.sv
// Gapped row position mapper: builds a run table from an alignment row and maps
// columns to sequence indexes and back. Clear and append complete without a search;
// queries run a binary search over the run RAM of up to 12 steps, each step one
// probe (read plus compare) through the probe, wait and next states. One request is
// in the back end at a time. Reset empties the row; the run RAM is not cleared,
// since only entries below the run count are ever used.
`default_nettype none
module gapped_row_position_mapper (
  input wire logic clk_i,
  input wire logic rst_ni,
  grpm_req_if.sink   in_req,
  grpm_rsp_if.source out_rsp
);
  import grpm_pkg::*;

  // The front queue holds requests while the back end searches.
  logic q_valid, q_pop;
  req_t q_req;

  grpm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_req.valid), .in_ready_o(in_req.ready), .in_req_i(in_req.payload),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req));

  // The back end owns all row state and produces one response per request.
  grpm_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_req_i(q_req),
    .out_valid_o(out_rsp.valid), .out_ready_i(out_rsp.ready),
    .out_rsp_o(out_rsp.payload));
endmodule
`default_nettype wire

>>> design/grpm_checker.sv
// Port-level checker for the gapped row position mapper, bound to the top level.
// Depends on grpm_pkg.
`default_nettype none
module grpm_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire grpm_pkg::rsp_t rsp
);
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(rsp)) else $error("response changed");
  a_found_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !(rsp.found && rsp.out_of_range)) else $error("found and oor");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp.found |-> rsp.mapped_position == '0) else $error("stray value");
  a_letters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp.sequence_letters <= rsp.row_columns) else $error("counts");
endmodule

bind gapped_row_position_mapper grpm_checker u_grpm_checker (
  .clk_i, .rst_ni, .rsp_valid(out_rsp.valid), .rsp_ready(out_rsp.ready),
  .rsp(out_rsp.payload));
`default_nettype wire

>>> bench/tb_grpm_if.sv
`timescale 1ns / 1ps
// Bench-side note: the request and response channel interfaces live with the design
// (grpm_if.sv); this file only holds the scoreboard class used by tb_top. Depends on grpm_pkg.
class grpm_scoreboard;
  grpm_pkg::rsp_t expected_q[$];
  int unsigned mismatches;
  // Predictor state, kept in step with the block.
  logic [12:0] run_col[2049];
  logic [12:0] run_idx[2049];
  int unsigned run_cnt;
  int unsigned col_total;
  int unsigned let_total;
  bit prev_gap;

  function new();
    mismatches = 0;
    run_cnt = 0;
    col_total = 0;
    let_total = 0;
    prev_gap = 1;
  endfunction

  // First entry greater than value among the first n entries of the chosen table.
  function int unsigned upper_idx(bit by_index, int unsigned n, int unsigned value);
    int unsigned lo, cnt, half, probe, v;
    lo = 0;
    cnt = n;
    while (cnt > 0) begin
      half = cnt / 2;
      probe = lo + half;
      v = by_index ? run_idx[probe] : run_col[probe];
      if (!(value < v)) begin
        lo = probe + 1;
        cnt = cnt - half - 1;
      end else begin
        cnt = half;
      end
    end
    return lo;
  endfunction

  function bit map_column(logic [2:0] cmd, int unsigned pos, output int unsigned res);
    int unsigned up, k, nxt, glen, off, ld, rd;
    res = 0;
    up = upper_idx(0, run_cnt, pos);
    if (up == 0) begin
      if (cmd == grpm_pkg::CmdExact || cmd == grpm_pkg::CmdLeft || run_cnt == 0) return 0;
      return 1;
    end
    k = up - 1;
    nxt = (k + 1 < run_cnt) ? run_idx[k + 1] : let_total;
    glen = nxt - run_idx[k];
    off = pos - run_col[k];
    if (off < glen) begin
      res = run_idx[k] + off;
      return 1;
    end
    if (cmd == grpm_pkg::CmdExact) return 0;
    if (cmd == grpm_pkg::CmdLeft) begin
      res = nxt - 1;
      return 1;
    end
    if (k + 1 >= run_cnt) begin
      if (cmd == grpm_pkg::CmdRight || let_total == 0) return 0;
      res = let_total - 1;
      return 1;
    end
    if (cmd == grpm_pkg::CmdRight) begin
      res = nxt;
      return 1;
    end
    ld = off - glen + 1;
    rd = run_col[k + 1] - pos;
    res = (ld <= rd) ? nxt - 1 : nxt;
    return 1;
  endfunction

  // Note an accepted request and queue the response it causes.
  function void note_request(grpm_pkg::req_t r);
    grpm_pkg::rsp_t e;
    int unsigned mapped, up, k;
    bit fnd, oor, letter;
    mapped = 0;
    fnd = 0;
    oor = 0;
    if (r.cmd == grpm_pkg::CmdNone) return;
    case (r.cmd)
      grpm_pkg::CmdClear: begin
        run_cnt = 0;
        col_total = 0;
        let_total = 0;
        prev_gap = 1;
      end
      grpm_pkg::CmdAppend: begin
        letter = (r.column_char != grpm_pkg::GapChar);
        if (col_total >= grpm_pkg::MaxColumns) begin
          oor = 1;
        end else if (letter && prev_gap && run_cnt >= grpm_pkg::MaxRuns) begin
          oor = 1;
        end else begin
          if (letter && prev_gap) begin
            run_col[run_cnt] = col_total;
            run_idx[run_cnt] = let_total;
            run_cnt++;
          end
          if (letter) let_total++;
          col_total++;
          prev_gap = !letter;
        end
      end
      grpm_pkg::CmdIndex: begin
        if (r.position >= let_total) begin
          oor = 1;
        end else begin
          up = upper_idx(1, run_cnt, r.position);
          if (up > 0) begin
            k = up - 1;
            mapped = run_col[k] + (r.position - run_idx[k]);
            fnd = 1;
          end
        end
      end
      default: begin
        if (r.position >= col_total) oor = 1;
        else fnd = map_column(r.cmd, r.position, mapped);
      end
    endcase
    if (!fnd) mapped = 0;
    e.mapped_position = mapped[11:0];
    e.found = fnd;
    e.out_of_range = oor;
    e.row_columns = col_total[12:0];
    e.sequence_letters = let_total[12:0];
    expected_q.push_back(e);
  endfunction

  function void check_response(grpm_pkg::rsp_t a);
    grpm_pkg::rsp_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected response %h", $time, a);
      mismatches++;
      return;
    end
    e = expected_q.pop_front();
    if (a.mapped_position !== e.mapped_position) begin
      $display("%0t: mapped_position exp %0d got %0d", $time, e.mapped_position,
               a.mapped_position);
      mismatches++;
    end
    if (a.found !== e.found) begin
      $display("%0t: found exp %0d got %0d", $time, e.found, a.found);
      mismatches++;
    end
    if (a.out_of_range !== e.out_of_range) begin
      $display("%0t: out_of_range exp %0d got %0d", $time, e.out_of_range, a.out_of_range);
      mismatches++;
    end
    if (a.row_columns !== e.row_columns) begin
      $display("%0t: row_columns exp %0d got %0d", $time, e.row_columns, a.row_columns);
      mismatches++;
    end
    if (a.sequence_letters !== e.sequence_letters) begin
      $display("%0t: sequence_letters exp %0d got %0d", $time, e.sequence_letters,
               a.sequence_letters);
      mismatches++;
    end
  endfunction
endclass

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Top-level bench for gapped_row_position_mapper: random and directed requests
// checked against an in-bench predictor. Depends on grpm_pkg, grpm_if and tb_grpm_if.
module tb_top;
  import grpm_pkg::*;

  logic clk_i;
  logic rst_ni;
  grpm_req_if in_req();
  grpm_rsp_if out_rsp();

  gapped_row_position_mapper i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_req (in_req.sink),
    .out_rsp(out_rsp.source)
  );

  grpm_scoreboard board;
  int unsigned send_idle_pct;   // chance, in percent, that the sender idles a cycle
  int unsigned recv_stall_pct;  // chance, in percent, that the receiver stalls a cycle
  longint unsigned cycle_count;
  localparam longint unsigned CycleLimit = 2000000;
  bit rdy;
  logic rsp_take;
  rsp_t rsp_hold;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    in_req.valid = 1'b0;
    in_req.payload = '0;
    out_rsp.ready = 1'b0;
    rsp_take = 1'b0;
    rsp_hold = '0;
    rst_ni = 1'b0;
  end

  // Watchdog: the slowest correct run stays far below this.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** gapped_row_position_mapper: FAILED **");
      $finish;
    end
  end
  initial cycle_count = 0;

  // Receiver: ready changes at the falling edge. Valid and payload only move at the
  // rising edge, so the values noted here are the ones the next rising edge sees.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rdy = ($urandom_range(99) >= recv_stall_pct);
      out_rsp.ready <= rdy;
      rsp_take <= out_rsp.valid && rdy;
      rsp_hold <= out_rsp.payload;
    end
  end
  always @(posedge clk_i) begin
    if (rsp_take) board.check_response(rsp_hold);
  end

  // Send one request; the predictor sees it at the edge where it is accepted.
  // Valid stays high afterwards until the next request or drain decides otherwise.
  task automatic send_request(logic [2:0] cmd, logic [7:0] ch, logic [11:0] pos);
    req_t r;
    bit acc;
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk_i);
    end
    r.cmd = cmd;
    r.column_char = ch;
    r.position = pos;
    in_req.valid <= 1'b1;
    in_req.payload <= r;
    do begin
      acc = in_req.ready;
      @(posedge clk_i);
      if (!acc) @(negedge clk_i);
    end while (!acc);
    board.note_request(r);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == GapChar);
    return c;
  endfunction

  // Append a random row of n columns; gap_pct sets how gappy it is.
  task automatic build_row(int unsigned n, int unsigned gap_pct);
    for (int unsigned i = 0; i < n; i++)
      send_request(CmdAppend, ($urandom_range(99) < gap_pct) ? GapChar : rand_letter(),
                   12'($urandom));
  endtask

  // Mostly in-range queries, with some past the end of the row.
  task automatic query_burst(int unsigned n);
    logic [2:0] cmd;
    int unsigned lim;
    for (int unsigned i = 0; i < n; i++) begin
      cmd = 3'($urandom_range(CmdExact, CmdIndex));
      lim = (cmd == CmdIndex) ? board.let_total : board.col_total;
      if ($urandom_range(9) == 0 || lim == 0)
        send_request(cmd, 8'($urandom), 12'($urandom));
      else send_request(cmd, 8'($urandom), 12'($urandom_range(lim + 1)));
    end
  endtask

  // Wait until every expected response has arrived, then a short settle.
  task automatic drain();
    in_req.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    board = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: queries on an empty row, the unused command, then a small row "-LL--L-".
    send_request(CmdExact, 8'h00, 12'd0);
    send_request(CmdIndex, 8'hFF, 12'hFFF);
    send_request(CmdNone, 8'hFF, 12'hFFF);
    send_request(CmdAppend, GapChar, 12'd0);
    send_request(CmdNearest, 8'h00, 12'd0);
    send_request(CmdRight, 8'h00, 12'd0);
    send_request(CmdAppend, 8'h00, 12'd0);
    send_request(CmdAppend, 8'hFF, 12'hFFF);
    send_request(CmdAppend, GapChar, 12'd0);
    send_request(CmdAppend, GapChar, 12'd0);
    send_request(CmdAppend, 8'h41, 12'd0);
    send_request(CmdAppend, GapChar, 12'd0);
    for (int unsigned c = CmdExact; c <= CmdNearest; c++) begin
      send_request(c[2:0], 8'h00, 12'd0);
      send_request(c[2:0], 8'h00, 12'd3);
      send_request(c[2:0], 8'h00, 12'd6);
    end
    send_request(CmdIndex, 8'h00, 12'd2);
    send_request(CmdExact, 8'h00, 12'd7);
    send_request(CmdClear, 8'hFF, 12'hFFF);
    drain();

    // Random: short rows with random gaps, then query bursts, across the idling phases.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int unsigned r = 0; r < 10; r++) begin
        send_request(CmdClear, 8'($urandom), 12'($urandom));
        build_row($urandom_range(1, 40), $urandom_range(10, 70));
        query_burst($urandom_range(10, 25));
        if ($urandom_range(3) == 0)
          send_request(3'($urandom_range(7)), 8'($urandom), 12'($urandom));
      end
      drain();
    end

    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("** gapped_row_position_mapper: PASSED **");
    end else begin
      $display("** gapped_row_position_mapper: FAILED **");
    end
    $finish;
  end
endmodule
